// ----- design/itda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

	// ascii codes and character width
	localparam int CHAR_W = 7;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;

	// double dabble digit correction
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // capture a new word and clear the digit register
		logic shift;      // one double dabble step
		logic step_down;  // move the digit pointer one place down
		logic push_sign;  // load '-' into the output register
		logic push_digit; // load the pointed digit into the output register
	} itda_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic conv_done;  // last double dabble step in progress
		logic digit_zero; // pointed digit is zero
		logic ptr_zero;   // pointer at least significant digit
		logic neg;        // word is printed with a minus sign
		logic out_free;   // output register can take a beat this cycle
	} itda_status_t;

endpackage

`default_nettype wire

// ----- design/itda_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itda_dp #(
	parameter int VALUE_WIDTH = 32,
	parameter int DIGITS      = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [VALUE_WIDTH-1:0]       value,
	input  wire logic                         mode,
	input  wire itda_pkg::itda_cmd_t          cmd,
	output itda_pkg::itda_status_t            status,
	output logic [itda_pkg::CHAR_W-1:0]       character,
	output logic                              last,
	output logic                              out_valid,
	input  wire logic                         out_ready
);
	import itda_pkg::*;

	localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam int PTR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [3:0]             digit_q [DIGITS];
	logic [3:0]             digit_d [DIGITS];
	logic [PTR_W-1:0]       ptr_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [3:0]             cur_digit;
	logic                   out_free;

	// sign and magnitude of the incoming word
	assign neg_in = mode & value[VALUE_WIDTH-1];
	assign mag_in = neg_in ? (~value + VALUE_WIDTH'(1)) : value;

	// one double dabble step: correct each digit, then shift the next bit in
	always_comb begin
		logic [3:0] adj [DIGITS];
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (digit_q[i] >= BCD_ADJ_MIN) ? (digit_q[i] + BCD_ADJ) : digit_q[i];
		end
		for (int i = 0; i < DIGITS; i++) begin
			if (i == 0) begin
				digit_d[i] = {adj[i][2:0], mag_q[VALUE_WIDTH-1]};
			end else begin
				digit_d[i] = {adj[i][2:0], adj[i-1][3]};
			end
		end
	end

	assign cur_digit = digit_q[ptr_q];
	assign out_free  = !out_valid_q || out_ready;

	// status toward the controller
	always_comb begin
		status.conv_done  = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
		status.digit_zero = (cur_digit == 4'd0);
		status.ptr_zero   = (ptr_q == '0);
		status.neg        = neg_q;
		status.out_free   = out_free;
	end

	// bit counter, sign and digit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				neg_q <= neg_in;
				ptr_q <= PTR_W'(DIGITS - 1);
			end else begin
				if (cmd.shift) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmd.step_down) begin
					ptr_q <= ptr_q - PTR_W'(1);
				end
			end
		end
	end

	// magnitude shifter and digit register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
			for (int i = 0; i < DIGITS; i++) begin
				digit_q[i] <= 4'd0;
			end
		end else if (cmd.shift) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			for (int i = 0; i < DIGITS; i++) begin
				digit_q[i] <= digit_d[i];
			end
		end
	end

	// output register, one beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_sign || cmd.push_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.push_digit) begin
			char_q <= CHAR_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
			last_q <= (ptr_q == '0);
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

	// checks
	a_push_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_sign || cmd.push_digit) |-> out_free)
		else $error("itda_dp: beat pushed over a waiting beat");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q == CHAR_MINUS || (char_q >= CHAR_ZERO && char_q <= CHAR_NINE)))
		else $error("itda_dp: illegal character");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == CHAR_MINUS) |-> !last_q)
		else $error("itda_dp: minus sign marked last");

	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_digit |-> (cur_digit <= 4'd9))
		else $error("itda_dp: digit out of range");

endmodule

`default_nettype wire

// ----- design/itda_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itda_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire itda_pkg::itda_status_t status,
	output itda_pkg::itda_cmd_t         cmd
);
	import itda_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   skip_more;

	assign skip_more = status.digit_zero && !status.ptr_zero;
	assign in_ready  = (state_q == ST_IDLE);

	// commands from state and status
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_CONV: cmd.shift = 1'b1;
			ST_SKIP: cmd.step_down = skip_more;
			ST_SIGN: cmd.push_sign = status.out_free;
			ST_EMIT: begin
				cmd.push_digit = status.out_free;
				cmd.step_down  = status.out_free && !status.ptr_zero;
			end
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (status.conv_done) state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (!skip_more) state_q <= status.neg ? ST_SIGN : ST_EMIT;
				end
				ST_SIGN: begin
					if (status.out_free) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free && status.ptr_zero) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_CONV))
		else $error("itda_ctrl: load did not start conversion");

	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push_sign && cmd.push_digit))
		else $error("itda_ctrl: two pushes in one cycle");

	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_sign |=> (state_q == ST_EMIT))
		else $error("itda_ctrl: sign not followed by digits");

endmodule

`default_nettype wire

// ----- design/integer_to_decimal_ascii_core.sv -----
// integer_to_decimal_ascii_core: decimal ascii text of one binary word
//
// input channel s_axis: tdata carries the word (VALUE_WIDTH bits, zero padded
// to whole bytes), tuser the mode bit (0 unsigned, 1 two's complement).
// output channel m_axis: one beat per character, most significant first;
// tdata[6:0] is '-' or '0'..'9', tlast marks the final character of a word.
// leading zeros are dropped, zero gives the single beat '0'.
//
// timing: a word is taken only while the core is idle. the conversion is a
// bit-serial double dabble, one bit per cycle over all VALUE_WIDTH bits. a
// scan from the top digit skips leading zeros, one digit per cycle, then one
// character leaves per cycle while the receiver is ready. the output register
// lets the next word enter while the last beat waits.
// a stalled receiver holds the current beat and pauses character emission.
// reset clears the controller and the output valid; no beat is pending.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_ascii_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // value
	input  wire logic                                s_axis_tuser,  // mode
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [7:0]                               m_axis_tdata,  // character, pad
	output logic                                     m_axis_tlast
);
	import itda_pkg::*;

	localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;

	itda_cmd_t          cmd;
	itda_status_t       status;
	logic [CHAR_W-1:0]  character;

	itda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	itda_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGITS      (DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_axis_tdata[VALUE_WIDTH-1:0]),
		.mode      (s_axis_tuser),
		.cmd       (cmd),
		.status    (status),
		.character (character),
		.last      (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {{(8-CHAR_W){1'b0}}, character};

endmodule

`default_nettype wire
